/* rtl/core/sc2a_pkg.sv */
// ----------------------------------------------------------------------------
// sc2a_pkg
// Shared types, constants and the set-1 make code lookup for the scancode
// to ASCII character FIFO.
// ----------------------------------------------------------------------------
package sc2a_pkg;

  localparam int FifoDepth = 128;
  localparam int PtrW      = $clog2(FifoDepth);
  localparam int CharW     = 7;
  localparam int CodeW     = 8;

  typedef logic [PtrW-1:0]  ptr_t;
  typedef logic [CharW-1:0] char_t;
  typedef logic [CodeW-1:0] code_t;

  localparam logic ModeScan = 1'b0;
  localparam logic ModeRead = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // Advance a ring pointer, wrapping at the last slot.
  function automatic ptr_t next_slot(input ptr_t p);
    next_slot = (p == ptr_t'(FifoDepth - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  // US layout, set-1 make codes. Releases, unmapped and out-of-range codes
  // all land on the default arm and give zero.
  function automatic char_t key_to_ascii(input code_t code);
    char_t c;
    case (code)
      8'h01: c = 7'h1b;
      8'h02: c = 7'h31;
      8'h03: c = 7'h32;
      8'h04: c = 7'h33;
      8'h05: c = 7'h34;
      8'h06: c = 7'h35;
      8'h07: c = 7'h36;
      8'h08: c = 7'h37;
      8'h09: c = 7'h38;
      8'h0a: c = 7'h39;
      8'h0b: c = 7'h30;
      8'h0c: c = 7'h2d;
      8'h0d: c = 7'h3d;
      8'h0e: c = 7'h08;
      8'h0f: c = 7'h09;
      8'h10: c = 7'h71;
      8'h11: c = 7'h77;
      8'h12: c = 7'h65;
      8'h13: c = 7'h72;
      8'h14: c = 7'h74;
      8'h15: c = 7'h79;
      8'h16: c = 7'h75;
      8'h17: c = 7'h69;
      8'h18: c = 7'h6f;
      8'h19: c = 7'h70;
      8'h1a: c = 7'h5b;
      8'h1b: c = 7'h5d;
      8'h1c: c = 7'h0a;
      8'h1e: c = 7'h61;
      8'h1f: c = 7'h73;
      8'h20: c = 7'h64;
      8'h21: c = 7'h66;
      8'h22: c = 7'h67;
      8'h23: c = 7'h68;
      8'h24: c = 7'h6a;
      8'h25: c = 7'h6b;
      8'h26: c = 7'h6c;
      8'h27: c = 7'h3b;
      8'h28: c = 7'h27;
      8'h29: c = 7'h60;
      8'h2b: c = 7'h5c;
      8'h2c: c = 7'h7a;
      8'h2d: c = 7'h78;
      8'h2e: c = 7'h63;
      8'h2f: c = 7'h76;
      8'h30: c = 7'h62;
      8'h31: c = 7'h6e;
      8'h32: c = 7'h6d;
      8'h33: c = 7'h2c;
      8'h34: c = 7'h2e;
      8'h35: c = 7'h2f;
      8'h37: c = 7'h2a;
      8'h39: c = 7'h20;
      8'h47: c = 7'h37;
      8'h48: c = 7'h38;
      8'h49: c = 7'h39;
      8'h4a: c = 7'h2d;
      8'h4b: c = 7'h34;
      8'h4c: c = 7'h35;
      8'h4d: c = 7'h36;
      8'h4e: c = 7'h2b;
      8'h4f: c = 7'h31;
      8'h50: c = 7'h32;
      8'h51: c = 7'h33;
      8'h52: c = 7'h30;
      8'h53: c = 7'h2e;
      default: c = '0;
    endcase
    key_to_ascii = c;
  endfunction

endpackage

/* rtl/core/sc2a_ram.sv */
// ----------------------------------------------------------------------------
// sc2a_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sc2a_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/scancode_to_ascii_fifo_unit.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit
// Set-1 scancode translator feeding a character ring buffer.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries mode and scancode. With mode 0
// the scancode is translated; a nonzero character is pushed into the ring,
// releases and unmapped keys are dropped, and so is a character that arrives
// while the ring holds FifoDepth - 1 entries. A scancode item gives no output
// item.
// With mode 1 one character is popped and returned on the output channel
// (out_valid/out_ready) as character and buffer_empty. An empty ring answers
// with character 0 and buffer_empty 1, straight from the idle state. A pop of a
// non-empty ring goes through ST_READ, where the registered read data of the
// character RAM is loaded into the output register; in_ready is low in ST_READ.
// Results sit in an output register. Input is taken while that register is
// free or being emptied in the same cycle, so a stalled receiver holds at
// most one result and then stalls the input side.
// Reset clears both ring pointers (ring empty) and out_valid but not the
// payload or the RAM contents; no RAM entry is read before being written.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                mode,
  input  sc2a_pkg::code_t     scancode,
  output logic                out_valid,
  input  logic                out_ready,
  output sc2a_pkg::char_t     character,
  output logic                buffer_empty
);

  import sc2a_pkg::*;

  state_t state, state_next;
  ptr_t   wr_ptr, wr_ptr_next;
  ptr_t   rd_ptr, rd_ptr_next;
  ptr_t   wr_ptr_inc, rd_ptr_inc;
  char_t  push_char;
  char_t  rd_data;
  logic   accept;
  logic   is_empty, is_full;
  logic   do_push;
  logic   ram_rd_en;
  logic   load_empty, load_data;
  logic   out_valid_next;

  // Take input only in the idle cycle, and only when the result slot frees up.
  assign in_ready   = (state == ST_IDLE) & (~out_valid | out_ready);
  assign accept     = in_valid & in_ready;
  assign push_char  = key_to_ascii(scancode);
  assign wr_ptr_inc = next_slot(wr_ptr);
  assign rd_ptr_inc = next_slot(rd_ptr);
  assign is_empty   = (wr_ptr == rd_ptr);
  assign is_full    = (wr_ptr_inc == rd_ptr);
  assign do_push    = accept & (mode == ModeScan) & (push_char != '0) & ~is_full;

  sc2a_ram #(
    .Width (CharW),
    .Depth (FifoDepth)
  ) u_char_ram (
    .clk     (clk),
    .wr_en   (do_push),
    .wr_addr (wr_ptr),
    .wr_data (push_char),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_ptr),
    .rd_data (rd_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mode == ModeRead && !is_empty) begin
          state_next = ST_READ;
        end
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    ram_rd_en  = 1'b0;
    load_empty = 1'b0;
    load_data  = 1'b0;
    case (state)
      ST_IDLE: begin
        ram_rd_en  = accept & (mode == ModeRead) & ~is_empty;
        load_empty = accept & (mode == ModeRead) & is_empty;
      end
      ST_READ: load_data = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    wr_ptr_next    = do_push ? wr_ptr_inc : wr_ptr;
    rd_ptr_next    = load_data ? rd_ptr_inc : rd_ptr;
    out_valid_next = out_valid & ~out_ready;
    if (load_empty || load_data) begin
      out_valid_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      wr_ptr    <= wr_ptr_next;
      rd_ptr    <= rd_ptr_next;
      out_valid <= out_valid_next;
    end
  end

  // Hold the result payload until it is replaced by a new one.
  always_ff @(posedge clk) begin
    if (load_empty) begin
      character    <= '0;
      buffer_empty <= 1'b1;
    end else if (load_data) begin
      character    <= rd_data;
      buffer_empty <= 1'b0;
    end
  end

  // The output register must be free whenever RAM data lands.
  a_read_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid)
    else $error("RAM data arrived while output register was occupied");

  // A pop of a non-empty ring goes to the data cycle next.
  a_pop_enters_read: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ModeRead && !is_empty) |=> state == ST_READ)
    else $error("pop did not enter read cycle");

  // The data cycle advances the read pointer by one slot.
  a_rd_ptr_advance: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> rd_ptr == $past(rd_ptr_inc))
    else $error("read pointer did not advance after pop");

  // A push into a full ring leaves the write pointer alone.
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && mode == ModeScan && is_full) |=> $stable(wr_ptr))
    else $error("write pointer moved while ring was full");

  // Empty answers carry a zero character.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && buffer_empty) |-> character == '0)
    else $error("empty result with nonzero character");

endmodule

/* dv/scancode_to_ascii_fifo_unit_tb.sv */
// ----------------------------------------------------------------------------
// scancode_to_ascii_fifo_unit_tb
// Self-checking bench for the set-1 scancode to ASCII character FIFO. Make
// codes, releases, unmapped keys and read requests go in over a valid/ready
// channel. A scoreboard keeps its own copy of the ring and checks every
// returned character and empty flag in order. The run repeats under several
// sender idle and receiver stall mixes, and fills the ring past full.
// ----------------------------------------------------------------------------
module scancode_to_ascii_fifo_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sc2a_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int RunItems     = 1700;
  localparam int LastMakeCode = 'h53;

  // US layout, indexed by make code
  localparam char_t MakeCodeMap [0:LastMakeCode] = '{
    7'h00, 7'h1b, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36,
    7'h37, 7'h38, 7'h39, 7'h30, 7'h2d, 7'h3d, 7'h08, 7'h09,
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69,
    7'h6f, 7'h70, 7'h5b, 7'h5d, 7'h0a, 7'h00, 7'h61, 7'h73,
    7'h64, 7'h66, 7'h67, 7'h68, 7'h6a, 7'h6b, 7'h6c, 7'h3b,
    7'h27, 7'h60, 7'h00, 7'h5c, 7'h7a, 7'h78, 7'h63, 7'h76,
    7'h62, 7'h6e, 7'h6d, 7'h2c, 7'h2e, 7'h2f, 7'h00, 7'h2a,
    7'h00, 7'h20, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
    7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h37,
    7'h38, 7'h39, 7'h2d, 7'h34, 7'h35, 7'h36, 7'h2b, 7'h31,
    7'h32, 7'h33, 7'h30, 7'h2e
  };

  logic  clk          = 1'b0;
  logic  rst          = 1'b1;
  logic  in_valid     = 1'b0;
  logic  in_ready;
  logic  mode         = ModeScan;
  code_t scancode     = '0;
  logic  out_valid;
  logic  out_ready    = 1'b0;
  char_t character;
  logic  buffer_empty;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // Releases and everything past the last make code give zero.
  function automatic char_t key_char(code_t code);
    if (code > LastMakeCode) return '0;
    return MakeCodeMap[code];
  endfunction

  class char_fifo_scoreboard;
    char_t       ring [FifoDepth];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    char_t       exp_char  [$];
    logic        exp_empty [$];
    int          errors;
    int          stored;
    int          dropped_full;
    int          ignored;
    int          popped;
    int          empty_reads;

    function int unsigned advance(int unsigned p);
      return (p + 1 == FifoDepth) ? 0 : p + 1;
    endfunction

    function int pending();
      return exp_char.size();
    endfunction

    function void note_item(logic m, code_t code);
      char_t c;
      if (m == ModeScan) begin
        c = key_char(code);
        if (c == '0) begin
          ignored++;
        end else if (advance(wr_ptr) == rd_ptr) begin
          // ring full: drop the newcomer, keep what is stored
          dropped_full++;
        end else begin
          ring[wr_ptr] = c;
          wr_ptr = advance(wr_ptr);
          stored++;
        end
      end else if (rd_ptr == wr_ptr) begin
        exp_char.push_back('0);
        exp_empty.push_back(1'b1);
        empty_reads++;
      end else begin
        exp_char.push_back(ring[rd_ptr]);
        exp_empty.push_back(1'b0);
        rd_ptr = advance(rd_ptr);
        popped++;
      end
    endfunction

    function void check_result(char_t c, logic e);
      char_t ec;
      logic  ee;
      if (exp_char.size() == 0) begin
        $display("%0t: unexpected result: character %h, buffer_empty %b", $time, c, e);
        errors++;
        return;
      end
      ec = exp_char.pop_front();
      ee = exp_empty.pop_front();
      if (c !== ec) begin
        $display("%0t: character mismatch: expected %h, actual %h", $time, ec, c);
        errors++;
      end
      if (e !== ee) begin
        $display("%0t: buffer_empty mismatch: expected %b, actual %b", $time, ee, e);
        errors++;
      end
    endfunction
  endclass

  char_fifo_scoreboard sb;

  scancode_to_ascii_fifo_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .mode         (mode),
    .scancode     (scancode),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .character    (character),
    .buffer_empty (buffer_empty)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(character, buffer_empty);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic code_t mapped_code();
    code_t c;
    do c = code_t'($urandom_range(1, LastMakeCode)); while (key_char(c) == '0);
    return c;
  endfunction

  // Releases, codes past the table, and in-table keys with no character.
  function automatic code_t noise_code();
    code_t c;
    case ($urandom_range(2))
      0: c = code_t'($urandom_range(8'h80, 8'hff));
      1: c = code_t'($urandom_range(LastMakeCode + 1, 8'h7f));
      default: begin
        do c = code_t'($urandom_range(0, LastMakeCode)); while (key_char(c) != '0);
      end
    endcase
    return c;
  endfunction

  task automatic send_item(logic m, code_t code);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid <= 1'b1;
    mode     <= m;
    scancode <= code;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_item(m, code);
  endtask

  task automatic idle_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic push_burst(int n);
    repeat (n) begin
      if ($urandom_range(9) == 0) send_item(ModeScan, noise_code());
      send_item(ModeScan, mapped_code());
    end
  endtask

  task automatic read_burst(int n);
    repeat (n) send_item(ModeRead, code_t'($urandom_range(255)));
  endtask

  task automatic run_random(int target);
    int    done;
    int    n;
    int    kind;
    logic  m;
    code_t c;
    done = 0;
    while (done < target) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(FifoDepth, FifoDepth + 8)
                                     : $urandom_range(1, 40);
        push_burst(n);
        done += n;
      end else if (kind < 75) begin
        n = ($urandom_range(4) == 0) ? $urandom_range(FifoDepth / 2, FifoDepth + 4)
                                     : $urandom_range(1, 40);
        read_burst(n);
        done += n;
      end else begin
        n = $urandom_range(1, 30);
        repeat (n) begin
          m = logic'($urandom_range(1));
          c = code_t'($urandom_range(255));
          send_item(m, c);
          if (m == ModeRead || key_char(c) != '0) done++;
        end
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty read, each special key, drops and releases, then read back
    send_item(ModeRead, 8'h00);
    send_item(ModeScan, 8'h01);
    send_item(ModeScan, 8'h0e);
    send_item(ModeScan, 8'h0f);
    send_item(ModeScan, 8'h1c);
    send_item(ModeScan, 8'h47);
    send_item(ModeScan, 8'h53);
    send_item(ModeScan, 8'h54);
    send_item(ModeScan, 8'h00);
    send_item(ModeScan, 8'h2a);
    send_item(ModeScan, 8'h3b);
    send_item(ModeScan, 8'h3a);
    send_item(ModeScan, 8'h81);
    send_item(ModeScan, 8'hff);
    send_item(ModeScan, 8'h80);
    send_item(ModeRead, 8'hff);
    send_item(ModeRead, 8'h00);
    send_item(ModeRead, 8'h55);
    send_item(ModeRead, 8'haa);
    send_item(ModeRead, 8'h7f);
    send_item(ModeRead, 8'h80);
    send_item(ModeRead, 8'hff);
    idle_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin sender_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      if (phase == 0) begin
        // overfill the ring, then read past empty
        push_burst(FifoDepth + 3);
        read_burst(FifoDepth + 1);
      end
      run_random(RunItems / 4 - ((phase == 0) ? 2 * FifoDepth : 0));
      idle_until_drained();
    end

    repeat (16) @(posedge clk);
    $display("Run covered %0d stored characters, %0d dropped on a full ring, %0d ignored codes,",
             sb.stored, sb.dropped_full, sb.ignored);
    $display("%0d characters read back and %0d reads of an empty ring.",
             sb.popped, sb.empty_reads);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/sc2a_pkg.sv
rtl/core/sc2a_ram.sv
rtl/core/scancode_to_ascii_fifo_unit.sv
dv/scancode_to_ascii_fifo_unit_tb.sv
